// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/vocc_pkg.sv -----
// ----------------------------------------------------------------------------
// vocc_pkg
// Grid sizes, widths, codes and shared types of the voxel occupancy counter.
// ----------------------------------------------------------------------------
package vocc_pkg;

	localparam int unsigned CELLS_X    = 32;
	localparam int unsigned CELLS_Y    = 32;
	localparam int unsigned CELLS_Z    = 32;
	localparam int unsigned COUNT_BITS = 16;

	localparam int unsigned REG_W     = 15;
	localparam int unsigned COORD_W   = 16;
	localparam int unsigned OUT_IDX_W = 5;
	localparam int unsigned OUT_CNT_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned CELLS_XY  = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
	localparam int unsigned CELLS_MAX = (CELLS_XY > CELLS_Z) ? CELLS_XY : CELLS_Z;
	localparam int unsigned IDX_W     = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1;
	localparam int unsigned DEPTH     = CELLS_X * CELLS_Y * CELLS_Z;
	localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned DIV_CNT_W = $clog2(REG_W + 1);

	typedef logic [REG_W-1:0]      reg_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_COUNT = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_INDEX = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z   = 3'd5;

	localparam reg_t EXTENT_RST = 15'd32;
	localparam reg_t STEP_RST   = 15'd1;

	typedef struct packed {
		logic done;
		reg_t quo;
		reg_t rem;
	} div_res_t;

	function automatic reg_t axis_cap(logic [1:0] ax);
		reg_t cap;
		unique case (ax)
			2'd0:    cap = REG_W'(CELLS_X);
			2'd1:    cap = REG_W'(CELLS_Y);
			default: cap = REG_W'(CELLS_Z);
		endcase
		return cap;
	endfunction

endpackage

// ----- hdl/vocc_ram.sv -----
// ----------------------------------------------------------------------------
// vocc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vocc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/vocc_div.sv -----
// ----------------------------------------------------------------------------
// vocc_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vocc_div import vocc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  reg_t     dividend,
	input  reg_t     divisor,
	output div_res_t res
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	reg_t                 rem_q;
	reg_t                 quo_q;
	reg_t                 dvs_q;
	logic [REG_W:0]       shifted;
	logic [REG_W:0]       trial;

	assign shifted = {rem_q, quo_q[REG_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(REG_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[REG_W]) begin
				rem_q <= trial[REG_W-1:0];
				quo_q <= {quo_q[REG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[REG_W-1:0];
				quo_q <= {quo_q[REG_W-2:0], 1'b0};
			end
		end
	end

	assign res = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule

// ----- hdl/voxel_occupancy_counter.sv -----
// An in-range request visits each axis in turn through the shared 15-step divider,
// then a read and an update, and ends with the done strobe.
// An out-of-range point finishes early, at the first failing axis.
// Requests do not overlap: start is taken again in the strobe cycle.
// Reset: control registers return to defaults, then a clear pass over every cell holds busy.
// ----------------------------------------------------------------------------
// voxel_occupancy_counter
// 3-D grid of saturating cell counters with add, query, clear and index read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_occupancy_counter import vocc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic signed [COORD_W-1:0]   coord_x,
	input  logic signed [COORD_W-1:0]   coord_y,
	input  logic signed [COORD_W-1:0]   coord_z,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [REG_W-1:0]            cfg_data,
	output logic                        done,
	output logic                        in_range,
	output logic [OUT_IDX_W-1:0]        cell_x,
	output logic [OUT_IDX_W-1:0]        cell_y,
	output logic [OUT_IDX_W-1:0]        cell_z,
	output logic [OUT_CNT_W-1:0]        cell_count,
	output logic                        empty_res
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_AXIS,
		S_DIV,
		S_READ,
		S_UPD
	} state_t;

	state_t                     state_q;
	logic [1:0]                 ax_q;
	kind_t                      kind_q;
	logic signed [COORD_W-1:0]  crd_q [3];
	reg_t                       ext_q [3];
	reg_t                       step_q [3];
	idx_t                       cell_q [3];
	logic                       ok_q;
	addr_t                      clr_q;

	logic                       done_q;
	logic                       in_range_q;
	logic [OUT_IDX_W-1:0]       cell_x_q;
	logic [OUT_IDX_W-1:0]       cell_y_q;
	logic [OUT_IDX_W-1:0]       cell_z_q;
	logic [OUT_CNT_W-1:0]       cell_count_q;
	logic                       empty_q;

	logic signed [COORD_W-1:0]  crd;
	reg_t                       ext;
	reg_t                       stp;
	reg_t                       cap;
	logic                       pre_fail;
	logic                       div_start;
	reg_t                       div_a;
	div_res_t                   div_res;
	logic [REG_W+1:0]           span;
	logic                       pt_ok;
	reg_t                       ncell;
	reg_t                       clamp;
	idx_t                       axis_idx;
	addr_t                      addr;
	count_t                     rd_cnt;
	count_t                     new_cnt;
	logic                       mem_we;
	addr_t                      mem_waddr;
	count_t                     mem_wdata;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ext_q[i]  <= EXTENT_RST;
				step_q[i] <= STEP_RST;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXTENT_X: ext_q[0]  <= cfg_data;
				REG_EXTENT_Y: ext_q[1]  <= cfg_data;
				REG_EXTENT_Z: ext_q[2]  <= cfg_data;
				REG_STEP_X:   step_q[0] <= cfg_data;
				REG_STEP_Y:   step_q[1] <= cfg_data;
				REG_STEP_Z:   step_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Per-axis datapath around the shared divider
	assign crd      = crd_q[ax_q];
	assign ext      = ext_q[ax_q];
	assign stp      = (step_q[ax_q] == '0) ? REG_W'(1) : step_q[ax_q];
	assign cap      = axis_cap(ax_q);
	assign pre_fail = crd[COORD_W-1] || (crd[REG_W-1:0] >= ext);
	assign div_a    = (kind_q == KIND_INDEX) ? ext : crd[REG_W-1:0];
	assign div_start = (state_q == S_AXIS) && !((kind_q != KIND_INDEX) && pre_fail);

	vocc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (stp),
		.res      (div_res)
	);

	// Whole cell ends at or below the extent: c - r + step <= extent
	assign span  = {2'b00, crd[REG_W-1:0]} - {2'b00, div_res.rem} + {2'b00, stp};
	assign pt_ok = (div_res.quo < cap) && (span <= {2'b00, ext});

	assign ncell = (div_res.quo > cap) ? cap : div_res.quo;

	always_comb begin
		priority if (crd[COORD_W-1] || (ncell == '0)) begin
			clamp = '0;
		end else if (crd[REG_W-1:0] >= ncell) begin
			clamp = ncell - 1'b1;
		end else begin
			clamp = crd[REG_W-1:0];
		end
	end

	assign axis_idx = (kind_q == KIND_INDEX) ? clamp[IDX_W-1:0] : div_res.quo[IDX_W-1:0];

	assign addr = ADDR_W'((cell_q[2] * CELLS_Y + cell_q[1]) * CELLS_X + cell_q[0]);

	// Counter memory
	always_comb begin
		unique case (kind_q)
			KIND_ADD:   new_cnt = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
			KIND_CLEAR: new_cnt = '0;
			KIND_COUNT: new_cnt = rd_cnt;
			KIND_INDEX: new_cnt = rd_cnt;
		endcase
	end

	assign mem_we = (state_q == S_CLEAR) ||
		((state_q == S_UPD) && ok_q && ((kind_q == KIND_ADD) || (kind_q == KIND_CLEAR)));
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : new_cnt;

	vocc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr),
		.rdata (rd_cnt)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ax_q       <= '0;
			kind_q     <= KIND_ADD;
			ok_q       <= 1'b0;
			clr_q      <= '0;
			done_q     <= 1'b0;
			in_range_q <= 1'b0;
			empty_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q   <= kind_t'(kind);
						crd_q[0] <= coord_x;
						crd_q[1] <= coord_y;
						crd_q[2] <= coord_z;
						ax_q     <= '0;
						ok_q     <= 1'b1;
						state_q  <= S_AXIS;
					end
				end
				S_AXIS: begin
					if ((kind_q != KIND_INDEX) && pre_fail) begin
						ok_q    <= 1'b0;
						state_q <= S_UPD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						cell_q[ax_q] <= axis_idx;
						priority if ((kind_q != KIND_INDEX) && !pt_ok) begin
							ok_q    <= 1'b0;
							state_q <= S_UPD;
						end else if (ax_q == 2'd2) begin
							state_q <= S_READ;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= S_AXIS;
						end
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					done_q       <= 1'b1;
					in_range_q   <= ok_q;
					cell_x_q     <= ok_q ? OUT_IDX_W'(cell_q[0]) : '0;
					cell_y_q     <= ok_q ? OUT_IDX_W'(cell_q[1]) : '0;
					cell_z_q     <= ok_q ? OUT_IDX_W'(cell_q[2]) : '0;
					cell_count_q <= ok_q ? OUT_CNT_W'(new_cnt) : '0;
					empty_q      <= !ok_q || (new_cnt == '0);
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign in_range   = in_range_q;
	assign cell_x     = cell_x_q;
	assign cell_y     = cell_y_q;
	assign cell_z     = cell_z_q;
	assign cell_count = cell_count_q;
	assign empty_res  = empty_q;

	`ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_NEXT(a_one_word, clk, arst_n, done, !done)
	`ASSERT_IMPLY(a_out_of_range, clk, arst_n, done && !in_range, empty_res && (cell_count == '0))
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)

endmodule
